// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the handle pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/hps_pkg.sv =====
// Shared types, codes and constants of the handle pool.
package hps_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STACK_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IN_USE = 1'd1;

	// Result status codes
	localparam logic [1:0] STS_OK          = 2'd0;
	localparam logic [1:0] STS_EXHAUSTED   = 2'd1;
	localparam logic [1:0] STS_NOT_LENT    = 2'd2;
	localparam logic [1:0] STS_STACK_ORDER = 2'd3;

	// Operation codes
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ACQ_WB,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SWP_RD,
		S_SWP_WR1,
		S_SWP_WR2,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_LENT,
		RD_IDX,
		RD_TOP
	} rd_sel_t;

	typedef enum logic {
		WR_IDX_DATA,
		WR_TOP_HANDLE
	} wr_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       ld_item;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       we;
		wr_sel_t    wr_sel;
		logic       idx_load_top;
		logic       idx_dec;
		logic       acq_commit;
		logic       rel_commit;
		logic       set_status;
		logic [1:0] status_code;
		logic       out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic op;
		logic exhausted;
		logic lent_zero;
		logic match;
		logic idx_zero;
		logic idx_is_top;
		logic stack_mode;
		logic out_busy;
	} stat_t;

endpackage

// ===== src/handle_pool_stack_heap.sv =====
// Top level of the handle pool: sequencer and datapath.
//
// Pool of DEPTH handles kept in a single-port slot table. One word goes in
// at a time and gives one result word. An acquire takes one slot table read
// and one update. A release searches the lent slots from the top down with
// one table read and one compare per slot, at most all lent slots; the swap
// costs one more read and two writes on the same port. Errors (exhausted,
// not lent, stack order) finish earlier and leave the pool unchanged. The
// slot table needs no clearing pass: each entry carries a valid bit and reads
// as its own index until written. A finished result waits in the output
// register until taken; the next word is accepted meanwhile.
module handle_pool_stack_heap #(
	parameter int DEPTH = hps_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [3:0]                     handle_in,
	input  logic [31:0]                    usage_mark,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [3:0]                     handle_out,
	output logic [1:0]                     status,
	output logic [3:0]                     frames_above,
	output logic [4:0]                     live_count,
	output logic [4:0]                     live_peak,
	output logic [31:0]                    acquire_total,
	output logic [31:0]                    usage_peak
);

	hps_pkg::cmd_t  cmd;
	hps_pkg::stat_t stat;

	hps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hps_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.handle_in     (handle_in),
		.usage_mark    (usage_mark),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.handle_out    (handle_out),
		.status        (status),
		.frames_above  (frames_above),
		.live_count    (live_count),
		.live_peak     (live_peak),
		.acquire_total (acquire_total),
		.usage_peak    (usage_peak)
	);

endmodule

// ===== src/hps_ctrl.sv =====
// Sequencer of the handle pool: steps acquire, search and swap.
module hps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hps_pkg::stat_t stat,
	output hps_pkg::cmd_t  cmd
);

	hps_pkg::state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hps_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			hps_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_nx    = hps_pkg::S_DISPATCH;
				end
			end
			hps_pkg::S_DISPATCH: begin
				if (stat.op == hps_pkg::OP_ACQUIRE) begin
					if (stat.exhausted) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = hps_pkg::STS_EXHAUSTED;
						state_nx        = hps_pkg::S_FIN;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = hps_pkg::RD_LENT;
						state_nx   = hps_pkg::S_ACQ_WB;
					end
				end else begin
					if (stat.lent_zero) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = hps_pkg::STS_NOT_LENT;
						state_nx        = hps_pkg::S_FIN;
					end else begin
						cmd.idx_load_top = 1'b1;
						state_nx         = hps_pkg::S_SRCH_RD;
					end
				end
			end
			hps_pkg::S_ACQ_WB: begin
				cmd.acq_commit = 1'b1;
				state_nx       = hps_pkg::S_FIN;
			end
			hps_pkg::S_SRCH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = hps_pkg::RD_IDX;
				state_nx   = hps_pkg::S_SRCH_CMP;
			end
			hps_pkg::S_SRCH_CMP: begin
				if (stat.match) begin
					if (stat.stack_mode && !stat.idx_is_top) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = hps_pkg::STS_STACK_ORDER;
						state_nx        = hps_pkg::S_FIN;
					end else begin
						state_nx = hps_pkg::S_SWP_RD;
					end
				end else if (stat.idx_zero) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = hps_pkg::STS_NOT_LENT;
					state_nx        = hps_pkg::S_FIN;
				end else begin
					cmd.idx_dec = 1'b1;
					state_nx    = hps_pkg::S_SRCH_RD;
				end
			end
			hps_pkg::S_SWP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = hps_pkg::RD_TOP;
				state_nx   = hps_pkg::S_SWP_WR1;
			end
			hps_pkg::S_SWP_WR1: begin
				cmd.we     = 1'b1;
				cmd.wr_sel = hps_pkg::WR_IDX_DATA;
				state_nx   = hps_pkg::S_SWP_WR2;
			end
			hps_pkg::S_SWP_WR2: begin
				cmd.we         = 1'b1;
				cmd.wr_sel     = hps_pkg::WR_TOP_HANDLE;
				cmd.rel_commit = 1'b1;
				state_nx       = hps_pkg::S_FIN;
			end
			hps_pkg::S_FIN: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = hps_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = hps_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/hps_datapath.sv =====
// Datapath of the handle pool: slot table, counters, item and result registers.
module hps_datapath #(
	parameter int DEPTH = hps_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           op,
	input  logic [3:0]                     handle_in,
	input  logic [31:0]                    usage_mark,
	input  hps_pkg::cmd_t                  cmd,
	output hps_pkg::stat_t                 stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [3:0]                     handle_out,
	output logic [1:0]                     status,
	output logic [3:0]                     frames_above,
	output logic [4:0]                     live_count,
	output logic [4:0]                     live_peak,
	output logic [31:0]                    acquire_total,
	output logic [31:0]                    usage_peak
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam int HCW  = (AW > 4) ? AW : 4;
	localparam int LCW  = (CNTW > 5) ? CNTW : 5;

	// Configuration
	logic                           stack_q;
	logic [hps_pkg::CFG_DATA_W-1:0] depth_q;

	// Pool state
	logic [CNTW-1:0] lent_q;
	logic [CNTW-1:0] peak_q;
	logic [31:0]     total_q;
	logic [31:0]     umax_q;

	// Current word and search index
	logic            op_q;
	logic [3:0]      handle_q;
	logic [31:0]     mark_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   res_handle_q;
	logic [1:0]      res_status_q;
	logic [AW-1:0]   res_above_q;

	// Slot table with per-entry valid bits; an unwritten slot holds its own index
	logic [AW-1:0]    slot_mem [DEPTH];
	logic [DEPTH-1:0] slot_v_q;
	logic [AW-1:0]    mem_rd_q;
	logic             rd_v_q;
	logic [AW-1:0]    rd_addr_q;

	logic [AW-1:0]   top_w;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   wr_data;
	logic [AW-1:0]   rdata;
	logic [HCW-1:0]  handle_ext;
	logic [CNTW-1:0] lent_inc;

	assign top_w      = AW'(lent_q - CNTW'(1));
	assign handle_ext = HCW'(handle_q);
	assign rdata      = rd_v_q ? mem_rd_q : rd_addr_q;
	assign lent_inc   = lent_q + CNTW'(1);

	// Address and data selection for the slot table
	always_comb begin
		case (cmd.rd_sel)
			hps_pkg::RD_LENT: rd_addr = AW'(lent_q);
			hps_pkg::RD_IDX:  rd_addr = idx_q;
			hps_pkg::RD_TOP:  rd_addr = top_w;
			default:          rd_addr = idx_q;
		endcase
		case (cmd.wr_sel)
			hps_pkg::WR_IDX_DATA: begin
				wr_addr = idx_q;
				wr_data = rdata;
			end
			hps_pkg::WR_TOP_HANDLE: begin
				wr_addr = top_w;
				wr_data = handle_ext[AW-1:0];
			end
			default: begin
				wr_addr = idx_q;
				wr_data = rdata;
			end
		endcase
	end

	// Slot table storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			mem_rd_q  <= slot_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Valid bits and the valid flag of the last read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_q <= '0;
			rd_v_q   <= 1'b0;
		end else begin
			if (cmd.we) begin
				slot_v_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_v_q <= slot_v_q[rd_addr];
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_q <= 1'b0;
			depth_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				hps_pkg::CFG_STACK_MODE:   stack_q <= cfg_data[0];
				hps_pkg::CFG_DEPTH_IN_USE: depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counters and peaks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lent_q  <= '0;
			peak_q  <= '0;
			total_q <= '0;
			umax_q  <= '0;
		end else begin
			if (cmd.acq_commit) begin
				lent_q <= lent_inc;
				if (lent_inc > peak_q) begin
					peak_q <= lent_inc;
				end
				if (total_q != '1) begin
					total_q <= total_q + 32'd1;
				end
			end
			if (cmd.rel_commit) begin
				lent_q <= lent_q - CNTW'(1);
				if (mark_q > umax_q) begin
					umax_q <= mark_q;
				end
			end
		end
	end

	// Word capture, search index and pending result fields
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			op_q         <= op;
			handle_q     <= handle_in;
			mark_q       <= usage_mark;
			res_handle_q <= '0;
			res_status_q <= hps_pkg::STS_OK;
			res_above_q  <= '0;
		end
		if (cmd.idx_load_top) begin
			idx_q <= top_w;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.acq_commit) begin
			res_handle_q <= rdata;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status_code;
			if (cmd.status_code == hps_pkg::STS_STACK_ORDER) begin
				res_above_q <= top_w - idx_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			handle_out    <= 4'(res_handle_q);
			status        <= res_status_q;
			frames_above  <= 4'(res_above_q);
			live_count    <= 5'(lent_q);
			live_peak     <= 5'(peak_q);
			acquire_total <= total_q;
			usage_peak    <= umax_q;
		end
	end

	// Status toward the controller
	always_comb begin
		stat.op         = op_q;
		stat.exhausted  = (LCW'(lent_q) >= LCW'(depth_q)) || (lent_q >= CNTW'(DEPTH));
		stat.lent_zero  = (lent_q == '0);
		stat.match      = (HCW'(rdata) == handle_ext);
		stat.idx_zero   = (idx_q == '0);
		stat.idx_is_top = (idx_q == top_w);
		stat.stack_mode = stack_q;
		stat.out_busy   = out_valid && !out_ready;
	end

endmodule

// ===== src/hps_checker.sv =====
// Port-level checks of the handle pool and their binding to the top level.
`include "assert_macros.svh"

module hps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  handle_out,
	input logic [1:0]  status,
	input logic [3:0]  frames_above,
	input logic [4:0]  live_count,
	input logic [4:0]  live_peak,
	input logic [31:0] acquire_total
);

	// A stalled result word holds
	`HPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(handle_out) && $stable(live_count) && $stable(acquire_total), "result word changed while stalled")

	// Only a successful word may carry a handle
	`HPS_ASSERT_IMPL(a_handle_ok, clk, arst_n, out_valid && status != hps_pkg::STS_OK, handle_out == 4'd0, "handle given on a failed word")

	// Frame count only on stack order violations
	`HPS_ASSERT_IMPL(a_frames, clk, arst_n, out_valid && frames_above != 4'd0, status == hps_pkg::STS_STACK_ORDER, "frames above without stack violation")

	// Live peak never below the live count
	`HPS_ASSERT_IMPL(a_peak, clk, arst_n, out_valid, live_peak >= live_count, "live peak below live count")

endmodule

bind handle_pool_stack_heap hps_checker u_hps_checker (.*);

// ===== tb/handle_pool_stack_heap_tb.sv =====
// Testbench for the handle pool: random and directed words checked against a predicted pool.
`timescale 1ns / 1ps

module handle_pool_stack_heap_tb;

	localparam int POOL_SLOTS  = hps_pkg::DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 300;
	localparam int HOLD_CYCLES = 150;

	// How a release word picks its handle when it is driven
	typedef enum logic [1:0] {
		PICK_GIVEN,
		PICK_TOP,
		PICK_ANY_LENT,
		PICK_BOTTOM
	} pick_t;

	typedef struct {
		logic        op;
		pick_t       pick;
		logic [3:0]  handle;
		logic [31:0] mark;
	} send_word_t;

	typedef struct {
		logic [3:0]  handle;
		logic [1:0]  status;
		logic [3:0]  above;
		logic [4:0]  live;
		logic [4:0]  live_hi;
		logic [31:0] grants;
		logic [31:0] usage;
	} pool_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index = hps_pkg::CFG_STACK_MODE;
	logic [hps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           op = hps_pkg::OP_ACQUIRE;
	logic [3:0]                     handle_in = '0;
	logic [31:0]                    usage_mark = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [3:0]                     handle_out;
	logic [1:0]                     status;
	logic [3:0]                     frames_above;
	logic [4:0]                     live_count;
	logic [4:0]                     live_peak;
	logic [31:0]                    acquire_total;
	logic [31:0]                    usage_peak;

	// Predicted pool state and register copies
	logic [3:0]  slot_of [POOL_SLOTS];
	logic [4:0]  lent_n = '0;
	logic [4:0]  lent_hi = '0;
	logic [31:0] grants = '0;
	logic [31:0] usage_hi = '0;
	logic        stack_on = 1'b0;
	logic [4:0]  depth_set = 5'd16;

	send_word_t   words_to_send [$];
	pool_result_t results_due [$];

	int  errors = 0;
	int  results_taken = 0;
	int  cycles = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  quiet_tail = 1'b0;

	handle_pool_stack_heap dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.handle_in    (handle_in),
		.usage_mark   (usage_mark),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.handle_out   (handle_out),
		.status       (status),
		.frames_above (frames_above),
		.live_count   (live_count),
		.live_peak    (live_peak),
		.acquire_total(acquire_total),
		.usage_peak   (usage_peak)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < POOL_SLOTS; i++)
			slot_of[i] = 4'(i);
	end

	// Apply one accepted word to the predicted pool, return its result
	function automatic pool_result_t pool_step(logic op_w, logic [3:0] h, logic [31:0] mark);
		pool_result_t r;
		int unsigned  eff;
		int           hit_at;
		logic [4:0]   top;
		r = '{default: '0};
		eff = (depth_set < POOL_SLOTS) ? depth_set : POOL_SLOTS;
		hit_at = -1;
		if (op_w == hps_pkg::OP_ACQUIRE) begin
			if (lent_n >= eff) begin
				r.status = hps_pkg::STS_EXHAUSTED;
			end else begin
				r.handle = slot_of[lent_n];
				lent_n++;
				if (lent_n > lent_hi)
					lent_hi = lent_n;
				if (grants != 32'hFFFF_FFFF)
					grants++;
			end
		end else begin
			// table is a permutation, so at most one lent slot matches
			for (int i = 0; i < int'(lent_n); i++)
				if (slot_of[i] == h)
					hit_at = i;
			if (hit_at < 0) begin
				r.status = hps_pkg::STS_NOT_LENT;
			end else begin
				top = lent_n - 5'd1;
				if (stack_on && hit_at != int'(top)) begin
					r.status = hps_pkg::STS_STACK_ORDER;
					r.above = 4'(int'(top) - hit_at);
				end else begin
					if (mark > usage_hi)
						usage_hi = mark;
					slot_of[hit_at] = slot_of[top];
					slot_of[top] = h;
					lent_n = top;
				end
			end
		end
		r.live = lent_n;
		r.live_hi = lent_hi;
		r.grants = grants;
		r.usage = usage_hi;
		return r;
	endfunction

	// Resolve a release handle against the pool as this word will see it
	function automatic logic [3:0] pick_handle(send_word_t w);
		if (w.op == hps_pkg::OP_ACQUIRE || lent_n == 0)
			return w.handle;
		case (w.pick)
			PICK_TOP:      return slot_of[lent_n - 5'd1];
			PICK_ANY_LENT: return slot_of[$urandom_range(0, int'(lent_n) - 1)];
			PICK_BOTTOM:   return slot_of[0];
			default:       return w.handle;
		endcase
	endfunction

	function automatic bit field_ok(string label, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Driver: predict on accept, then offer the next pending word
	always @(posedge clk) begin : drive_words
		send_word_t w;
		logic       keep;
		keep = in_valid;
		if (in_valid && in_ready) begin
			results_due.push_back(pool_step(op, handle_in, usage_mark));
			keep = 1'b0;
		end
		if (!keep && arst_n && words_to_send.size() != 0) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				send_gap = $urandom_range(0, 4);
			end else begin
				w = words_to_send.pop_front();
				keep = 1'b1;
				op <= w.op;
				handle_in <= pick_handle(w);
				usage_mark <= w.mark;
			end
		end
		in_valid <= keep;
	end

	// Monitor: check each taken result, then pick next ready
	always @(posedge clk) begin : check_results
		pool_result_t want;
		bit           bad;
		logic         rdy;
		bad = 1'b0;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with nothing expected: handle %0h, status %0h",
					$time, handle_out, status);
				errors++;
			end else begin
				want = results_due.pop_front();
				bad |= !field_ok("handle_out", 32'(want.handle), 32'(handle_out));
				bad |= !field_ok("status", 32'(want.status), 32'(status));
				bad |= !field_ok("frames_above", 32'(want.above), 32'(frames_above));
				bad |= !field_ok("live_count", 32'(want.live), 32'(live_count));
				bad |= !field_ok("live_peak", 32'(want.live_hi), 32'(live_peak));
				bad |= !field_ok("acquire_total", want.grants, acquire_total);
				bad |= !field_ok("usage_peak", want.usage, usage_peak);
				if (bad)
					errors++;
			end
			results_taken++;
		end
		rdy = 1'b1;
		// one long hold-off so the block backs up and drops in_ready
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!hold_done && results_taken >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rdy = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			rdy = 1'b0;
		end
		out_ready <= rdy;
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_word(logic op_w, pick_t pick, logic [3:0] h, logic [31:0] mark);
		words_to_send.push_back('{op: op_w, pick: pick, handle: h, mark: mark});
	endtask

	// Block idle: nothing pending, nothing offered, nothing outstanding
	task automatic wait_idle();
		do @(negedge clk);
		while (words_to_send.size() != 0 || in_valid || results_due.size() != 0);
	endtask

	task automatic write_reg(logic [hps_pkg::CFG_IDX_W-1:0] idx,
			logic [hps_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == hps_pkg::CFG_STACK_MODE)
			stack_on = val[0];
		else
			depth_set = val;
	endtask

	// Mostly well-formed traffic: releases of lent handles, some misuse mixed in
	task automatic run_phase(logic mode, logic [4:0] depth, int count, int acq_pct);
		int r;
		wait_idle();
		write_reg(hps_pkg::CFG_STACK_MODE, hps_pkg::CFG_DATA_W'(mode));
		write_reg(hps_pkg::CFG_DEPTH_IN_USE, depth);
		@(negedge clk);
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < acq_pct)
				queue_word(hps_pkg::OP_ACQUIRE, PICK_GIVEN, 4'($urandom), $urandom);
			else if (r < 93 && mode && $urandom_range(0, 6) != 0)
				queue_word(hps_pkg::OP_RELEASE, PICK_TOP, 4'($urandom), $urandom);
			else if (r < 93)
				queue_word(hps_pkg::OP_RELEASE, PICK_ANY_LENT, 4'($urandom), $urandom);
			else
				queue_word(hps_pkg::OP_RELEASE, PICK_GIVEN, 4'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: heap pool, full depth
		queue_word(hps_pkg::OP_RELEASE, PICK_GIVEN, 4'd0, 32'h0000_1234);
		for (int i = 0; i < POOL_SLOTS; i++)
			queue_word(hps_pkg::OP_ACQUIRE, PICK_GIVEN, (i % 2) ? 4'hF : 4'h0,
				(i % 2) ? 32'hFFFF_FFFF : 32'h0);
		queue_word(hps_pkg::OP_ACQUIRE, PICK_GIVEN, 4'h5, 32'h0);
		queue_word(hps_pkg::OP_RELEASE, PICK_GIVEN, 4'd3, 32'h0);
		queue_word(hps_pkg::OP_RELEASE, PICK_GIVEN, 4'd15, 32'hFFFF_FFFF);
		queue_word(hps_pkg::OP_RELEASE, PICK_GIVEN, 4'd3, 32'h0000_0001);
		wait_idle();

		// Stack pool: release far below the top, then the top
		write_reg(hps_pkg::CFG_STACK_MODE, hps_pkg::CFG_DATA_W'(1));
		@(negedge clk);
		queue_word(hps_pkg::OP_RELEASE, PICK_BOTTOM, 4'h0, 32'h0);
		queue_word(hps_pkg::OP_RELEASE, PICK_TOP, 4'h0, 32'h8000_0000);
		wait_idle();

		// Depth lowered under the live count
		write_reg(hps_pkg::CFG_DEPTH_IN_USE, 5'd4);
		@(negedge clk);
		queue_word(hps_pkg::OP_ACQUIRE, PICK_GIVEN, 4'hA, 32'h0);
		queue_word(hps_pkg::OP_RELEASE, PICK_TOP, 4'h0, 32'h7FFF_FFFF);

		run_phase(1'b0, 5'd16, 200, 55);
		run_phase(1'b1, 5'd16, 180, 55);
		run_phase(1'b0, 5'd1, 120, 50);
		run_phase(1'b1, 5'd1, 100, 50);
		run_phase(1'b0, 5'd0, 80, 40);
		run_phase(1'b0, 5'd31, 200, 65);
		run_phase(1'b1, 5'd5, 150, 55);
		run_phase(1'b0, 5'($urandom_range(2, 15)), 150, 50);
		wait_idle();
		quiet_tail = 1'b1;
		run_phase(1'b1, 5'd16, 150, 70);
		wait_idle();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
